// ===== rtl/dwt_pkg.sv =====
// Shared types, constants and tables for the waveform tuner generator.
package dwt_pkg;

   localparam int DEF_MAX_POINTS = 1024;

   // divider widths: dividend (quotient) and divisor
   localparam int QW = 44;
   localparam int DW = 40;

   localparam logic [26:0] CLOCK_HZ    = 27'd84000000;
   localparam logic [19:0] MAXN_NUM    = 20'd1000000;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [19:0] ERR_SAT     = 20'hFFFFF;

   localparam logic [0:0] CSR_WAVE_SHAPE = 1'd0;
   localparam logic [0:0] CSR_PHASE_TURN = 1'd1;

   typedef enum logic [1:0] {
      KIND_RETUNE = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_NOP    = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [19:0] hz;
   } item_type;

   typedef struct packed {
      logic        shape;
      logic [15:0] phase;
   } cfg_type;

   typedef struct packed {
      logic [9:0]  value;
      logic [9:0]  index;
      logic [10:0] points;
      logic [23:0] reload;
      logic [19:0] error;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  pre;
      logic [31:0] mul;
      logic [5:0]  post;
   } recip_type;

   // Horner divisors of the sine series, innermost first, as a shift and a
   // reciprocal multiply: v / (2^pre * b) = ((v >> pre) * mul) >> post,
   // exact for any 32-bit v
   function automatic recip_type horner_recip(input logic [2:0] k);
      recip_type r;
      unique case (k)
         3'd0:    r = '{pre: 2'd1, mul: 32'd2498890064, post: 6'd37};
         3'd1:    r = '{pre: 2'd3, mul: 32'd3817748708, post: 6'd35};
         3'd2:    r = '{pre: 2'd1, mul: 32'd3272356036, post: 6'd36};
         3'd3:    r = '{pre: 2'd2, mul: 32'd3435973837, post: 6'd34};
         default: r = '{pre: 2'd1, mul: 32'd2863311531, post: 6'd33};
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/dac_waveform_tuner_generator.sv =====
// Sample and retune times are set mostly by the shared divider, one quotient bit per cycle.
// Throughput: one transaction at a time in the sequencer; a two-entry input queue and
// an output register let either side stall on its own.
// Reset (synchronous): 10 points, reload 0, error 0, index 0, sine, phase 0, queues empty.
module dac_waveform_tuner_generator
   import dwt_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_func,
   input  logic [19:0] req_target_hz,
   output logic        empty,
   input  logic        pop,
   output logic [9:0]  rsp_sample_value,
   output logic [9:0]  rsp_sample_index,
   output logic [10:0] rsp_points,
   output logic [23:0] rsp_timer_reload,
   output logic [19:0] rsp_freq_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff;
   logic     head_valid, take;
   item_type head;
   logic     res_valid, res_free, res_take;
   rsp_type  res;

   dwt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .func       (req_func),
      .target_hz  (req_target_hz),
      .full       (full),
      .head_valid (head_valid),
      .head       (head),
      .take       (take)
   );

   dwt_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .take       (take),
      .res_valid  (res_valid),
      .res        (res),
      .res_free   (res_free)
   );

   assign csr_ready = 1'b1;
   assign empty     = !rsp_valid_ff;
   assign res_free  = !rsp_valid_ff || pop;
   assign res_take  = res_valid && res_free;

   assign rsp_sample_value = rsp_ff.value;
   assign rsp_sample_index = rsp_ff.index;
   assign rsp_points       = rsp_ff.points;
   assign rsp_timer_reload = rsp_ff.reload;
   assign rsp_freq_error   = rsp_ff.error;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WAVE_SHAPE: cfg_in.shape = csr_wdata[0];
            CSR_PHASE_TURN: cfg_in.phase = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   a_push_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      push && !full |=> head_valid)
      else $error("accepted transaction missing from input queue");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      res_take |=> !empty)
      else $error("finished result not presented");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && !empty && !res_take |=> empty)
      else $error("result slot not released after pop");

endmodule

// ===== rtl/dwt_front.sv =====
// Input queue that takes and classifies incoming transactions.
module dwt_front
   import dwt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        func,
   input  logic [19:0] target_hz,
   output logic        full,
   output logic        head_valid,
   output item_type    head,
   input  logic        take
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_take;
   item_type   item_new;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_take    = take && head_valid;

   always_comb begin
      item_new.hz = target_hz;
      if (func) begin
         item_new.kind = KIND_SAMPLE;
      end else if (target_hz == 20'd0) begin
         item_new.kind = KIND_NOP;
      end else begin
         item_new.kind = KIND_RETUNE;
      end
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

// ===== rtl/dwt_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module dwt_div
   import dwt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [QW-1:0] quot,
   output logic [DW-1:0] rem
);

   localparam int CNTW = $clog2(QW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [QW-1:0]   quo_ff, quo_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   den_ff, den_in;
   logic [DW:0]     trial;
   logic            ge;

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

   always_comb begin
      trial   = {rem_ff, quo_ff[QW-1]};
      ge      = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(QW);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
         quo_in = {quo_ff[QW-2:0], ge};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

// ===== rtl/dwt_back.sv =====
// Sequencer that runs retune searches and computes waveform samples.
module dwt_back
   import dwt_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     head_valid,
   input  item_type head,
   output logic     take,
   output logic     res_valid,
   output rsp_type  res,
   input  logic     res_free
);

   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int IW = $clog2(MAX_POINTS);
   localparam int TW = NW + 2;

   typedef enum logic [30:0] {
      ST_IDLE      = 31'h1 << 0,
      ST_DIVW      = 31'h1 << 1,
      ST_RT_START  = 31'h1 << 2,
      ST_RT_MAXN   = 31'h1 << 3,
      ST_RT_NF     = 31'h1 << 4,
      ST_RT_ARR_IS = 31'h1 << 5,
      ST_RT_ARR    = 31'h1 << 6,
      ST_RT_NC     = 31'h1 << 7,
      ST_RT_FR_IS  = 31'h1 << 8,
      ST_RT_FR     = 31'h1 << 9,
      ST_RT_NEXT   = 31'h1 << 10,
      ST_RT_COMMIT = 31'h1 << 11,
      ST_SM_START  = 31'h1 << 12,
      ST_TR_MUL    = 31'h1 << 13,
      ST_TR_IS     = 31'h1 << 14,
      ST_TR_FIN    = 31'h1 << 15,
      ST_SN_IS     = 31'h1 << 16,
      ST_SN_ANG    = 31'h1 << 17,
      ST_SN_X      = 31'h1 << 18,
      ST_SN_XS     = 31'h1 << 19,
      ST_SN_X2     = 31'h1 << 20,
      ST_SN_X2S    = 31'h1 << 21,
      ST_SN_HM     = 31'h1 << 22,
      ST_SN_HD_IS  = 31'h1 << 23,
      ST_SN_T      = 31'h1 << 24,
      ST_SN_S      = 31'h1 << 25,
      ST_SN_SS     = 31'h1 << 26,
      ST_SN_M      = 31'h1 << 27,
      ST_SN_FIN    = 31'h1 << 28,
      ST_SM_ADV    = 31'h1 << 29,
      ST_FIN       = 31'h1 << 30
   } state_type;

   state_type     state_ff, state_in;
   state_type     ret_ff, ret_in;

   // architectural state
   logic [NW-1:0] pts_ff, pts_in;
   logic [26:0]   clk_ff, clk_in;
   logic [19:0]   err_ff, err_in;
   logic [IW-1:0] idx_ff, idx_in;

   // working registers
   kind_type      kind_ff, kind_in;
   logic [19:0]   f_ff, f_in;
   logic [NW-1:0] n_ff, n_in;
   logic [26:0]   c_ff, c_in;
   logic          second_ff, second_in;
   logic          found_ff, found_in;
   logic [26:0]   berr_ff, berr_in;
   logic [NW-1:0] bn_ff, bn_in;
   logic [26:0]   barr_ff, barr_in;
   logic [IW-1:0] i_ff, i_in;
   logic [1:0]    quad_ff, quad_in;
   logic [30:0]   r_ff, r_in;
   logic [31:0]   x_ff, x_in;
   logic [31:0]   x2_ff, x2_in;
   logic [30:0]   t_ff, t_in;
   logic [31:0]   s_ff, s_in;
   logic [2:0]    k_ff, k_in;
   logic [9:0]    value_ff, value_in;

   logic [31:0]   mul_a, mul_b;
   logic [63:0]   mul_p_ff;

   logic          div_start;
   logic [QW-1:0] div_num;
   logic [DW-1:0] div_den;
   logic          div_done;
   logic [QW-1:0] div_q;
   logic [DW-1:0] div_r;

   logic [31:0]   angle;
   logic [26:0]   fr, e;
   logic [10:0]   fl, ce;
   logic [11:0]   tri_v;
   logic [TW-1:0] i4, n3;
   logic [39:0]   m_up;

   recip_type     hr;
   logic [31:0]   hv;
   logic [63:0]   hq;

   dwt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q),
      .rem   (div_r)
   );

   assign take      = (state_ff == ST_IDLE) && head_valid;
   assign res_valid = (state_ff == ST_FIN);

   // Horner division operand and quotient
   assign hr = horner_recip(k_ff);
   assign hv = (k_ff == 3'd0) ? x2_ff : mul_p_ff[61:30];
   assign hq = mul_p_ff >> hr.post;

   always_comb begin
      res.value  = (kind_ff == KIND_SAMPLE) ? value_ff : 10'd0;
      res.index  = (kind_ff == KIND_SAMPLE) ? 10'(i_ff) : 10'd0;
      res.points = 11'(pts_ff);
      res.reload = 24'(clk_ff - 27'd1);
      res.error  = err_ff;
   end

   // shared multiplier operands
   always_comb begin
      unique case (state_ff)
         ST_RT_NF:    begin mul_a = 32'(n_ff);        mul_b = 32'(f_ff);        end
         ST_RT_NC:    begin mul_a = 32'(n_ff);        mul_b = 32'(c_ff);        end
         ST_TR_MUL:   begin mul_a = 32'(i_ff);        mul_b = 32'd1600;         end
         ST_SN_X:     begin mul_a = 32'(r_ff);        mul_b = 32'(HALF_PI_Q30); end
         ST_SN_X2:    begin mul_a = x_ff;             mul_b = x_ff;             end
         ST_SN_HM:    begin mul_a = x2_ff;            mul_b = 32'(t_ff);        end
         ST_SN_HD_IS: begin mul_a = hv >> hr.pre;     mul_b = hr.mul;           end
         ST_SN_S:     begin mul_a = x_ff;             mul_b = 32'(t_ff);        end
         ST_SN_M:     begin mul_a = s_ff;             mul_b = 32'd400;          end
         default:     begin mul_a = 32'd0;            mul_b = 32'd0;            end
      endcase
   end

   // shared divider operands
   always_comb begin
      div_start = 1'b1;
      unique case (state_ff)
         ST_RT_START: begin
            div_num = QW'(MAXN_NUM);
            div_den = DW'(f_ff);
         end
         ST_RT_ARR_IS, ST_RT_FR_IS: begin
            div_num = QW'(CLOCK_HZ);
            div_den = mul_p_ff[DW-1:0];
         end
         ST_TR_IS: begin
            div_num = QW'(mul_p_ff[31:0]);
            div_den = DW'(pts_ff);
         end
         ST_SN_IS: begin
            div_num = QW'({i_ff, 32'h0});
            div_den = DW'(pts_ff);
         end
         default: begin
            div_start = 1'b0;
            div_num   = '0;
            div_den   = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      pts_in    = pts_ff;
      clk_in    = clk_ff;
      err_in    = err_ff;
      idx_in    = idx_ff;
      kind_in   = kind_ff;
      f_in      = f_ff;
      n_in      = n_ff;
      c_in      = c_ff;
      second_in = second_ff;
      found_in  = found_ff;
      berr_in   = berr_ff;
      bn_in     = bn_ff;
      barr_in   = barr_ff;
      i_in      = i_ff;
      quad_in   = quad_ff;
      r_in      = r_ff;
      x_in      = x_ff;
      x2_in     = x2_ff;
      t_in      = t_ff;
      s_in      = s_ff;
      k_in      = k_ff;
      value_in  = value_ff;

      angle = div_q[31:0] + {cfg.phase, 16'h0};
      fr    = div_q[26:0];
      e     = (fr > 27'(f_ff)) ? fr - 27'(f_ff) : 27'(f_ff) - fr;
      fl    = div_q[10:0];
      ce    = fl + {10'd0, (div_r != '0)};
      i4    = TW'(i_ff) << 2;
      n3    = TW'(pts_ff) + (TW'(pts_ff) << 1);
      if (i4 < TW'(pts_ff)) begin
         tri_v = 12'd520 + 12'(fl);
      end else if (i4 < n3) begin
         tri_v = 12'd1320 - 12'(ce);
      end else begin
         tri_v = 12'(fl) - 12'd1080;
      end
      m_up = mul_p_ff[39:0] + 40'(ONE_Q30) - 40'd1;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               kind_in = head.kind;
               f_in    = head.hz;
               unique case (head.kind)
                  KIND_RETUNE: state_in = ST_RT_START;
                  KIND_SAMPLE: state_in = ST_SM_START;
                  default:     state_in = ST_FIN;
               endcase
            end
         end
         ST_DIVW: begin
            if (div_done) begin
               state_in = ret_ff;
            end
         end
         ST_RT_START: begin
            ret_in   = ST_RT_MAXN;
            state_in = ST_DIVW;
         end
         ST_RT_MAXN: begin
            if (div_q < QW'(10)) begin
               n_in = NW'(10);
            end else if (div_q > QW'(MAX_POINTS)) begin
               n_in = NW'(MAX_POINTS);
            end else begin
               n_in = NW'(div_q);
            end
            found_in = 1'b0;
            berr_in  = '0;
            bn_in    = NW'(10);
            barr_in  = 27'd1;
            state_in = ST_RT_NF;
         end
         ST_RT_NF:     state_in = ST_RT_ARR_IS;
         ST_RT_ARR_IS: begin
            ret_in   = ST_RT_ARR;
            state_in = ST_DIVW;
         end
         ST_RT_ARR: begin
            // skip n whose reload rounds down to zero
            if (div_q == '0) begin
               state_in = ST_RT_NEXT;
            end else begin
               c_in      = div_q[26:0];
               second_in = 1'b0;
               state_in  = ST_RT_NC;
            end
         end
         ST_RT_NC:    state_in = ST_RT_FR_IS;
         ST_RT_FR_IS: begin
            ret_in   = ST_RT_FR;
            state_in = ST_DIVW;
         end
         ST_RT_FR: begin
            if (!found_ff || e < berr_ff) begin
               found_in = 1'b1;
               berr_in  = e;
               bn_in    = n_ff;
               barr_in  = c_ff;
            end
            if (!second_ff) begin
               c_in      = c_ff + 27'd1;
               second_in = 1'b1;
               state_in  = ST_RT_NC;
            end else begin
               state_in = ST_RT_NEXT;
            end
         end
         ST_RT_NEXT: begin
            if (n_ff == NW'(10)) begin
               state_in = ST_RT_COMMIT;
            end else begin
               n_in     = n_ff - NW'(1);
               state_in = ST_RT_NF;
            end
         end
         ST_RT_COMMIT: begin
            pts_in = bn_ff;
            clk_in = barr_ff;
            if (!found_ff || berr_ff > 27'(ERR_SAT)) begin
               err_in = ERR_SAT;
            end else begin
               err_in = berr_ff[19:0];
            end
            idx_in   = '0;
            state_in = ST_FIN;
         end
         ST_SM_START: begin
            i_in     = (NW'(idx_ff) >= pts_ff) ? '0 : idx_ff;
            state_in = cfg.shape ? ST_TR_MUL : ST_SN_IS;
         end
         ST_TR_MUL: state_in = ST_TR_IS;
         ST_TR_IS: begin
            ret_in   = ST_TR_FIN;
            state_in = ST_DIVW;
         end
         ST_TR_FIN: begin
            value_in = tri_v[9:0];
            state_in = ST_SM_ADV;
         end
         ST_SN_IS: begin
            ret_in   = ST_SN_ANG;
            state_in = ST_DIVW;
         end
         ST_SN_ANG: begin
            // fold the angle into the first quarter turn
            quad_in  = angle[31:30];
            r_in     = angle[30] ? ONE_Q30 - {1'b0, angle[29:0]} : {1'b0, angle[29:0]};
            state_in = ST_SN_X;
         end
         ST_SN_X:  state_in = ST_SN_XS;
         ST_SN_XS: begin
            x_in     = mul_p_ff[61:30];
            state_in = ST_SN_X2;
         end
         ST_SN_X2:  state_in = ST_SN_X2S;
         ST_SN_X2S: begin
            x2_in    = mul_p_ff[61:30];
            k_in     = 3'd0;
            state_in = ST_SN_HD_IS;
         end
         ST_SN_HM:    state_in = ST_SN_HD_IS;
         ST_SN_HD_IS: state_in = ST_SN_T;
         ST_SN_T: begin
            t_in = ONE_Q30 - hq[30:0];
            if (k_ff == 3'd4) begin
               state_in = ST_SN_S;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = ST_SN_HM;
            end
         end
         ST_SN_S:  state_in = ST_SN_SS;
         ST_SN_SS: begin
            s_in     = mul_p_ff[61:30];
            state_in = ST_SN_M;
         end
         ST_SN_M:   state_in = ST_SN_FIN;
         ST_SN_FIN: begin
            if (!quad_ff[1]) begin
               value_in = 10'd520 + {1'b0, mul_p_ff[38:30]};
            end else begin
               value_in = 10'd520 - {1'b0, m_up[38:30]};
            end
            state_in = ST_SM_ADV;
         end
         ST_SM_ADV: begin
            // advance the index and wrap at the period length
            idx_in   = (NW'(i_ff) + NW'(1) >= pts_ff) ? '0 : i_ff + IW'(1);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (res_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         pts_ff   <= NW'(10);
         clk_ff   <= 27'd1;
         err_ff   <= '0;
         idx_ff   <= '0;
         kind_ff  <= KIND_NOP;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pts_ff   <= pts_in;
         clk_ff   <= clk_in;
         err_ff   <= err_in;
         idx_ff   <= idx_in;
         kind_ff  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_p_ff  <= mul_a * mul_b;
      f_ff      <= f_in;
      n_ff      <= n_in;
      c_ff      <= c_in;
      second_ff <= second_in;
      found_ff  <= found_in;
      berr_ff   <= berr_in;
      bn_ff     <= bn_in;
      barr_ff   <= barr_in;
      i_ff      <= i_in;
      quad_ff   <= quad_in;
      r_ff      <= r_in;
      x_ff      <= x_in;
      x2_ff     <= x2_in;
      t_ff      <= t_in;
      s_ff      <= s_in;
      k_ff      <= k_in;
      value_ff  <= value_in;
   end

endmodule
